/* design/stsum_pkg.sv */
// Shared types, constants and the control program of the range-sum tree.
package stsum_pkg;

    // Field widths of the ports.
    localparam int CMD_W = 2;
    localparam int POS_W = 11;
    localparam int VAL_W = 16;
    localparam int OUT_W = 26;
    localparam int CNT_W = 11;

    // Defaults and limits.
    localparam int DEF_MAX_LEAVES = 1024;
    localparam logic [CNT_W-1:0] LEAF_COUNT_RESET = CNT_W'(1024);
    localparam logic [OUT_W-1:0] SUM_MAX = {OUT_W{1'b1}};

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

    // Program step addresses.
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_IDLE     = 4'd0;
    localparam logic [STEP_W-1:0] STEP_CLR      = 4'd1;
    localparam logic [STEP_W-1:0] STEP_CLR_END  = 4'd2;
    localparam logic [STEP_W-1:0] STEP_WR_LEAF  = 4'd3;
    localparam logic [STEP_W-1:0] STEP_WR_RD    = 4'd4;
    localparam logic [STEP_W-1:0] STEP_WR_SUM   = 4'd5;
    localparam logic [STEP_W-1:0] STEP_WR_END   = 4'd6;
    localparam logic [STEP_W-1:0] STEP_Q_SETUP  = 4'd7;
    localparam logic [STEP_W-1:0] STEP_Q_RD     = 4'd8;
    localparam logic [STEP_W-1:0] STEP_Q_ACC    = 4'd9;
    localparam logic [STEP_W-1:0] STEP_Q_OUT    = 4'd10;
    localparam logic [STEP_W-1:0] STEP_Q_END    = 4'd11;

    // Datapath operation of one step.
    typedef enum logic [3:0] {
        UOP_NOP,
        UOP_CLEAR,
        UOP_WLEAF,
        UOP_WREAD,
        UOP_WSUM,
        UOP_QSETUP,
        UOP_QREAD,
        UOP_QACC,
        UOP_QOUT
    } uop_t;

    // Jump condition of one step; when false the program falls through.
    typedef enum logic [3:0] {
        C_NEXT,
        C_ALWAYS,
        C_DISPATCH,
        C_CLR_MORE,
        C_WR_BAD,
        C_K_MORE,
        C_Q_EMPTY,
        C_Q_MORE,
        C_OUT_BUSY
    } cond_t;

    typedef struct packed {
        uop_t              uop;
        cond_t             cond;
        logic [STEP_W-1:0] target;
    } ucode_word_t;

    // Control from the sequencer to the datapath.
    typedef struct packed {
        uop_t uop;
        logic accept;
    } dp_ctrl_t;

    // Status from the datapath to the sequencer.
    typedef struct packed {
        logic clr_more;
        logic wr_bad;
        logic k_more;
        logic q_empty;
        logic q_more;
        logic out_busy;
    } dp_flags_t;

    // Control store: one word per step.
    function automatic ucode_word_t ucode_fetch(input logic [STEP_W-1:0] step);
        ucode_word_t w;
        unique case (step)
            STEP_IDLE:    w = '{UOP_NOP,    C_DISPATCH, STEP_IDLE};
            STEP_CLR:     w = '{UOP_CLEAR,  C_CLR_MORE, STEP_CLR};
            STEP_CLR_END: w = '{UOP_NOP,    C_ALWAYS,   STEP_IDLE};
            STEP_WR_LEAF: w = '{UOP_WLEAF,  C_WR_BAD,   STEP_IDLE};
            STEP_WR_RD:   w = '{UOP_WREAD,  C_NEXT,     STEP_IDLE};
            STEP_WR_SUM:  w = '{UOP_WSUM,   C_K_MORE,   STEP_WR_RD};
            STEP_WR_END:  w = '{UOP_NOP,    C_ALWAYS,   STEP_IDLE};
            STEP_Q_SETUP: w = '{UOP_QSETUP, C_Q_EMPTY,  STEP_Q_OUT};
            STEP_Q_RD:    w = '{UOP_QREAD,  C_NEXT,     STEP_IDLE};
            STEP_Q_ACC:   w = '{UOP_QACC,   C_Q_MORE,   STEP_Q_RD};
            STEP_Q_OUT:   w = '{UOP_QOUT,   C_OUT_BUSY, STEP_Q_OUT};
            STEP_Q_END:   w = '{UOP_NOP,    C_ALWAYS,   STEP_IDLE};
            default:      w = '{UOP_NOP,    C_ALWAYS,   STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

/* design/stsum_useq.sv */
// Microcode sequencer: step counter, control store fetch and jump logic.
module stsum_useq (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic [stsum_pkg::CMD_W-1:0]  command,
    output logic                         in_ready,
    output stsum_pkg::dp_ctrl_t          ctrl,
    input  stsum_pkg::dp_flags_t         flags
);

    logic [stsum_pkg::STEP_W-1:0] step_reg;
    logic [stsum_pkg::STEP_W-1:0] step_next;
    stsum_pkg::ucode_word_t       word;
    logic                         accept;
    logic                         take;

    assign word     = stsum_pkg::ucode_fetch(step_reg);
    assign in_ready = (step_reg == stsum_pkg::STEP_IDLE);
    assign accept   = in_valid && in_ready;
    assign ctrl     = '{uop: word.uop, accept: accept};

    // Evaluate the jump condition of the current word.
    always_comb
    begin
        case (word.cond)
            stsum_pkg::C_ALWAYS:   take = 1'b1;
            stsum_pkg::C_CLR_MORE: take = flags.clr_more;
            stsum_pkg::C_WR_BAD:   take = flags.wr_bad;
            stsum_pkg::C_K_MORE:   take = flags.k_more;
            stsum_pkg::C_Q_EMPTY:  take = flags.q_empty;
            stsum_pkg::C_Q_MORE:   take = flags.q_more;
            stsum_pkg::C_OUT_BUSY: take = flags.out_busy;
            default:               take = 1'b0;
        endcase
    end

    // Next step: dispatch on the command in idle, otherwise jump or fall through.
    always_comb
    begin
        if (word.cond == stsum_pkg::C_DISPATCH)
        begin
            step_next = stsum_pkg::STEP_IDLE;
            if (accept)
            begin
                unique case (command)
                    stsum_pkg::CMD_CLEAR: step_next = stsum_pkg::STEP_CLR;
                    stsum_pkg::CMD_WRITE: step_next = stsum_pkg::STEP_WR_LEAF;
                    stsum_pkg::CMD_QUERY: step_next = stsum_pkg::STEP_Q_SETUP;
                    default:              step_next = stsum_pkg::STEP_IDLE;
                endcase
            end
        end
        else if (take)
        begin
            step_next = word.target;
        end
        else
        begin
            step_next = step_reg + stsum_pkg::STEP_W'(1);
        end
    end

    // Reset starts in the clear program so the tree begins at zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= stsum_pkg::STEP_CLR;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

/* design/stsum_datapath.sv */
// Datapath: node memory, index registers, accumulator and result register.
module stsum_datapath #(
    parameter int MAX_LEAVES = stsum_pkg::DEF_MAX_LEAVES
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  stsum_pkg::dp_ctrl_t          ctrl,
    output stsum_pkg::dp_flags_t         flags,
    input  logic [stsum_pkg::POS_W-1:0]  first_position,
    input  logic [stsum_pkg::POS_W-1:0]  last_position,
    input  logic [stsum_pkg::VAL_W-1:0]  write_value,
    input  logic                         cfg_write_en,
    input  logic [stsum_pkg::CNT_W-1:0]  cfg_write_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [stsum_pkg::OUT_W-1:0]  range_sum
);

    localparam int NODES  = 2 * MAX_LEAVES;
    localparam int IDX_W  = $clog2(NODES);
    localparam int PTR_W  = IDX_W + 1;
    localparam int NSUM_W = stsum_pkg::VAL_W + $clog2(MAX_LEAVES);
    localparam int EXT_W  = (PTR_W > stsum_pkg::POS_W) ? PTR_W : stsum_pkg::POS_W;
    localparam int SAT_W  = (NSUM_W > stsum_pkg::OUT_W) ? NSUM_W : stsum_pkg::OUT_W;
    localparam logic [PTR_W-1:0] BASE     = PTR_W'(MAX_LEAVES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NODES - 1);
    localparam logic [EXT_W-1:0] MAX_EXT  = EXT_W'(MAX_LEAVES);

    // Node memory: one write port and two registered read ports.
    logic [NSUM_W-1:0] node_mem [NODES];
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [NSUM_W-1:0] mem_wdata;
    logic [IDX_W-1:0]  raddr_a;
    logic [IDX_W-1:0]  raddr_b;
    logic [NSUM_W-1:0] rd_a_reg;
    logic [NSUM_W-1:0] rd_b_reg;

    logic [stsum_pkg::CNT_W-1:0] leaf_count_reg;
    logic [stsum_pkg::POS_W-1:0] first_reg;
    logic [stsum_pkg::POS_W-1:0] last_reg;
    logic [stsum_pkg::VAL_W-1:0] value_reg;
    logic [IDX_W-1:0]  clr_reg, clr_next;
    logic [IDX_W-1:0]  k_reg, k_next;
    logic [PTR_W-1:0]  l_reg, l_next;
    logic [PTR_W-1:0]  r_reg, r_next;
    logic [NSUM_W-1:0] acc_reg, acc_next;
    logic              out_valid_reg, out_valid_next;
    logic [stsum_pkg::OUT_W-1:0] range_sum_reg, range_sum_next;

    logic [EXT_W-1:0]  limit;
    logic [EXT_W-1:0]  first_ext;
    logic [EXT_W-1:0]  last_ext;
    logic [EXT_W-1:0]  lo;
    logic [EXT_W-1:0]  hi;
    logic              wr_ok;
    logic [PTR_W-1:0]  leaf_ptr;
    logic [PTR_W-1:0]  l_inc;
    logic [PTR_W-1:0]  l_half;
    logic [PTR_W-1:0]  r_half;
    logic [NSUM_W-1:0] add_a;
    logic [NSUM_W-1:0] add_b;
    logic [SAT_W-1:0]  acc_ext;
    logic [stsum_pkg::OUT_W-1:0] acc_sat;
    logic              out_busy;

    // Range checks against the positions in use.
    always_comb
    begin
        limit     = (EXT_W'(leaf_count_reg) < MAX_EXT) ? EXT_W'(leaf_count_reg) : MAX_EXT;
        first_ext = EXT_W'(first_reg);
        last_ext  = EXT_W'(last_reg);
        wr_ok     = (first_ext != '0) && (first_ext <= limit);
        lo        = (first_ext == '0) ? EXT_W'(1) : first_ext;
        hi        = (last_ext > limit) ? limit : last_ext;
        leaf_ptr  = BASE + first_ext[PTR_W-1:0] - PTR_W'(1);
    end

    // One query level: take odd ends, then move both bounds up a level.
    always_comb
    begin
        l_inc   = l_reg + PTR_W'(l_reg[0]);
        l_half  = {1'b0, l_inc[PTR_W-1:1]};
        r_half  = {1'b0, r_reg[PTR_W-1:1]};
        add_a   = l_reg[0] ? rd_a_reg : '0;
        add_b   = r_reg[0] ? rd_b_reg : '0;
        acc_ext = SAT_W'(acc_reg);
        acc_sat = (acc_ext > SAT_W'(stsum_pkg::SUM_MAX)) ? stsum_pkg::SUM_MAX
                                                          : acc_ext[stsum_pkg::OUT_W-1:0];
    end

    assign out_busy = out_valid_reg && !out_ready;

    assign flags = '{
        clr_more: (clr_reg != LAST_IDX),
        wr_bad:   !wr_ok,
        k_more:   (k_reg[IDX_W-1:1] != '0),
        q_empty:  (lo > hi),
        q_more:   (l_half < r_half),
        out_busy: out_busy
    };

    // Read addresses: both children on the write path, both range ends on a query.
    always_comb
    begin
        case (ctrl.uop)
            stsum_pkg::UOP_WREAD:
            begin
                raddr_a = {k_reg[IDX_W-2:0], 1'b0};
                raddr_b = {k_reg[IDX_W-2:0], 1'b1};
            end
            default:
            begin
                raddr_a = l_reg[IDX_W-1:0];
                raddr_b = {r_reg[IDX_W-1:1], 1'b0};
            end
        endcase
    end

    // Operation decode.
    always_comb
    begin
        mem_we         = 1'b0;
        mem_waddr      = k_reg;
        mem_wdata      = rd_a_reg + rd_b_reg;
        clr_next       = clr_reg;
        k_next         = k_reg;
        l_next         = l_reg;
        r_next         = r_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg && !out_ready;
        range_sum_next = range_sum_reg;
        unique case (ctrl.uop)
            stsum_pkg::UOP_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                clr_next  = (clr_reg != LAST_IDX) ? clr_reg + IDX_W'(1) : '0;
            end
            stsum_pkg::UOP_WLEAF:
            begin
                mem_we    = wr_ok;
                mem_waddr = leaf_ptr[IDX_W-1:0];
                mem_wdata = NSUM_W'(value_reg);
                k_next    = {1'b0, leaf_ptr[IDX_W-1:1]};
            end
            stsum_pkg::UOP_WSUM:
            begin
                mem_we = 1'b1;
                k_next = {1'b0, k_reg[IDX_W-1:1]};
            end
            stsum_pkg::UOP_QSETUP:
            begin
                l_next   = BASE + lo[PTR_W-1:0] - PTR_W'(1);
                r_next   = BASE + hi[PTR_W-1:0];
                acc_next = '0;
            end
            stsum_pkg::UOP_QACC:
            begin
                acc_next = acc_reg + add_a + add_b;
                l_next   = l_half;
                r_next   = r_half;
            end
            stsum_pkg::UOP_QOUT:
            begin
                if (!out_busy)
                begin
                    out_valid_next = 1'b1;
                    range_sum_next = acc_sat;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Node memory.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            node_mem[mem_waddr] <= mem_wdata;
        end
        rd_a_reg <= node_mem[raddr_a];
        rd_b_reg <= node_mem[raddr_b];
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            first_reg <= first_position;
            last_reg  <= last_position;
            value_reg <= write_value;
        end
        k_reg         <= k_next;
        l_reg         <= l_next;
        r_reg         <= r_next;
        acc_reg       <= acc_next;
        range_sum_reg <= range_sum_next;
    end

    // Control and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            leaf_count_reg <= stsum_pkg::LEAF_COUNT_RESET;
            clr_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                leaf_count_reg <= cfg_write_data;
            end
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign range_sum = range_sum_reg;

endmodule

/* design/segment_tree_point_set_range_sum.sv */
// Top level of the range-sum tree with single-leaf writes.
//
//   Channel   Signals                                               Transfer when
//   input     in_valid, in_ready, command, first_position,          in_valid & in_ready
//             last_position, write_value
//   output    out_valid, out_ready, range_sum                       out_valid & out_ready
//   config    cfg_write_en, cfg_write_data (leaf_count)             cfg_write_en
//
// One item at a time; a new item is taken only when the sequencer is back at its idle step.
// Write: the leaf is stored, then each tree level takes a read of both children and a write of the sum.
// Query: a setup step, then a read and an accumulate step per level walked; clear zeroes every node.
// After reset a clear pass runs before the first item is taken.
// The result sits in an output register; a query waits there only if the previous
// result has not yet been taken.
module segment_tree_point_set_range_sum #(
    parameter int MAX_LEAVES = stsum_pkg::DEF_MAX_LEAVES
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [stsum_pkg::CMD_W-1:0]  command,
    input  logic [stsum_pkg::POS_W-1:0]  first_position,
    input  logic [stsum_pkg::POS_W-1:0]  last_position,
    input  logic [stsum_pkg::VAL_W-1:0]  write_value,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [stsum_pkg::OUT_W-1:0]  range_sum,
    input  logic                         cfg_write_en,
    input  logic [stsum_pkg::CNT_W-1:0]  cfg_write_data
);

    stsum_pkg::dp_ctrl_t  ctrl;
    stsum_pkg::dp_flags_t flags;

    // Control program.
    stsum_useq u_useq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .command  (command),
        .in_ready (in_ready),
        .ctrl     (ctrl),
        .flags    (flags)
    );

    // Tree storage and arithmetic.
    stsum_datapath #(
        .MAX_LEAVES (MAX_LEAVES)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (ctrl),
        .flags          (flags),
        .first_position (first_position),
        .last_position  (last_position),
        .write_value    (write_value),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .range_sum      (range_sum)
    );

endmodule
